>>> hw/rtl/fpr_pkg.sv
// Shared types, codes and helpers for the framed packet receiver.
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

  localparam logic [7:0] StartMarkerReset = 8'hFE;
  localparam logic [7:0] CsumLowCount     = 8'd2;
  localparam logic [7:0] CsumHighCount    = 8'd1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_CSUM = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_FRAMING = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ACCEPT  = 2'd2,
    EV_REJECT  = 2'd3
  } event_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] bytes_remaining;
    logic [7:0] length_held;
    logic [7:0] sum_low;
    logic [7:0] sum_high;
    logic [7:0] csum_low_byte;
  } frame_state_t;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        last_payload;
    logic [7:0]  frame_length;
    logic [15:0] computed_checksum;
    logic [15:0] received_checksum;
  } frame_result_t;

  // 8-bit add with the carry folded back into bit 0
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fpr_frame_core.sv
// Per-byte frame decode: next framing state and the result for one beat.
`timescale 1ns / 1ps
`default_nettype none

module fpr_frame_core (
  input  fpr_pkg::frame_state_t  state_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [7:0]             start_marker_i,
  output fpr_pkg::frame_state_t  state_o,
  output fpr_pkg::frame_result_t result_o
);

  logic [7:0]  sum_low_add;
  logic [15:0] recv_csum;
  logic [15:0] comp_csum;

  assign sum_low_add = fpr_pkg::eac_add(state_i.sum_low, rx_byte_i);
  assign recv_csum   = {rx_byte_i, state_i.csum_low_byte};
  assign comp_csum   = {state_i.sum_high, state_i.sum_low};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.event_res = fpr_pkg::EV_FRAMING;
    unique case (state_i.phase)
      fpr_pkg::PH_HUNT: begin
        if (rx_byte_i == start_marker_i) begin
          state_o.phase = fpr_pkg::PH_LEN;
        end
      end
      fpr_pkg::PH_LEN: begin
        state_o.length_held     = rx_byte_i;
        state_o.bytes_remaining = rx_byte_i;
        state_o.sum_low         = '0;
        state_o.sum_high        = '0;
        result_o.frame_length   = rx_byte_i;
        // empty frame: go straight to the checksum bytes
        if (rx_byte_i == 8'd0) begin
          state_o.bytes_remaining = fpr_pkg::CsumLowCount;
          state_o.phase           = fpr_pkg::PH_CSUM;
        end else begin
          state_o.phase = fpr_pkg::PH_PAY;
        end
      end
      fpr_pkg::PH_PAY: begin
        result_o.event_res     = fpr_pkg::EV_PAYLOAD;
        result_o.payload_byte  = rx_byte_i;
        result_o.payload_index = state_i.length_held - state_i.bytes_remaining;
        result_o.frame_length  = state_i.length_held;
        state_o.sum_low        = sum_low_add;
        state_o.sum_high       = fpr_pkg::eac_add(state_i.sum_high, sum_low_add);
        if (state_i.bytes_remaining > 8'd1) begin
          state_o.bytes_remaining = state_i.bytes_remaining - 8'd1;
        end else begin
          result_o.last_payload   = 1'b1;
          state_o.bytes_remaining = fpr_pkg::CsumLowCount;
          state_o.phase           = fpr_pkg::PH_CSUM;
        end
      end
      fpr_pkg::PH_CSUM: begin
        result_o.frame_length = state_i.length_held;
        if (state_i.bytes_remaining == fpr_pkg::CsumLowCount) begin
          state_o.csum_low_byte   = rx_byte_i;
          state_o.bytes_remaining = fpr_pkg::CsumHighCount;
        end else begin
          result_o.received_checksum = recv_csum;
          result_o.computed_checksum = comp_csum;
          result_o.event_res = (recv_csum == comp_csum) ? fpr_pkg::EV_ACCEPT
                                                        : fpr_pkg::EV_REJECT;
          state_o.bytes_remaining = '0;
          state_o.phase           = fpr_pkg::PH_HUNT;
        end
      end
      default: begin
        state_o.phase = fpr_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/framed_packet_receiver.sv
// Top level of the framed packet receiver with Fletcher-16 check.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | rx_byte_i
//  out     | source    | out_valid_o/out_stall_i | event_res_o .. received_checksum_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_data_i (start marker)
//
// One beat in, one beat out; a byte is taken every cycle unless in_stall_o is high.
// The whole decode is one combinational step between the framing state and
// the output register, which parts the two sides.
// in_stall_o is high only while a result sits in the output register and is stalled.
// Reset returns to hunting with zero sums and the start marker at 0xFE.
`timescale 1ns / 1ps
`default_nettype none

module framed_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic        last_payload_o,
  output logic [7:0]  frame_length_o,
  output logic [15:0] computed_checksum_o,
  output logic [15:0] received_checksum_o
);

  fpr_pkg::frame_state_t  state_q, state_d;
  fpr_pkg::frame_result_t res_q, res_d;
  logic [7:0]             marker_q;
  logic                   out_valid_q;
  logic                   in_fire;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  fpr_frame_core u_core (
    .state_i        (state_q),
    .rx_byte_i      (rx_byte_i),
    .start_marker_i (marker_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // all-zero state is hunting with cleared count and sums
      state_q     <= '0;
      marker_q    <= fpr_pkg::StartMarkerReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        marker_q <= cfg_data_i;
      end
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign event_res_o         = res_q.event_res;
  assign payload_byte_o      = res_q.payload_byte;
  assign payload_index_o     = res_q.payload_index;
  assign last_payload_o      = res_q.last_payload;
  assign frame_length_o      = res_q.frame_length;
  assign computed_checksum_o = res_q.computed_checksum;
  assign received_checksum_o = res_q.received_checksum;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted byte produced no result");

  a_hunt_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == fpr_pkg::PH_HUNT) |-> (state_q.bytes_remaining == 8'd0))
    else $error("count not cleared while hunting");

  a_csum_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == fpr_pkg::PH_CSUM) |->
      (state_q.bytes_remaining == fpr_pkg::CsumLowCount ||
       state_q.bytes_remaining == fpr_pkg::CsumHighCount))
    else $error("bad count in checksum phase");

  a_pay_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == fpr_pkg::PH_PAY) |->
      (state_q.bytes_remaining != 8'd0 &&
       state_q.bytes_remaining <= state_q.length_held))
    else $error("payload count out of range");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.event_res == fpr_pkg::EV_PAYLOAD) |->
      (res_q.payload_index < res_q.frame_length))
    else $error("payload index beyond frame length");

endmodule

`default_nettype wire

>>> dv/framed_packet_receiver_tb.sv
// Self-checking testbench for the framed packet receiver: directed and random framed traffic vs a predictor.
`timescale 1ns / 1ps

module framed_packet_receiver_tb;

  localparam int ClkHalf    = 6;
  localparam int CycleLimit = 300000;
  localparam int LongHold   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = 8'd0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data = 8'd0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        cfg_ready_o;
  logic        out_valid_o;
  logic [1:0]  event_res_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  payload_index_o;
  logic        last_payload_o;
  logic [7:0]  frame_length_o;
  logic [15:0] computed_checksum_o;
  logic [15:0] received_checksum_o;

  framed_packet_receiver dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .rx_byte_i           (rx_byte),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .event_res_o         (event_res_o),
    .payload_byte_o      (payload_byte_o),
    .payload_index_o     (payload_index_o),
    .last_payload_o      (last_payload_o),
    .frame_length_o      (frame_length_o),
    .computed_checksum_o (computed_checksum_o),
    .received_checksum_o (received_checksum_o)
  );

  initial forever #ClkHalf clk_i = ~clk_i;

  // Predictor state
  fpr_pkg::phase_e st_phase = fpr_pkg::PH_HUNT;
  logic [7:0] st_left = 8'd0;
  logic [7:0] st_len = 8'd0;
  logic [7:0] st_sum1 = 8'd0;
  logic [7:0] st_sum2 = 8'd0;
  logic [7:0] st_csum_lo = 8'd0;
  logic [7:0] st_marker = fpr_pkg::StartMarkerReset;

  logic [7:0]             tx_bytes[$];
  fpr_pkg::frame_result_t pending_results[$];
  int            gen_cnt = 0;
  int            acc_cnt = 0;
  int            err_cnt = 0;
  int            cycle_cnt = 0;
  bit            send_hold = 1'b0;
  int            hold_req = 0;

  // Ones' complement 8-bit add: wrap the carry back into the sum
  function automatic logic [7:0] ones_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t[8]) return t[7:0] + 8'd1;
    return t[7:0];
  endfunction

  function automatic fpr_pkg::frame_result_t decode_byte(input logic [7:0] b);
    fpr_pkg::frame_result_t r;
    r = '0;
    r.event_res = fpr_pkg::EV_FRAMING;
    case (st_phase)
      fpr_pkg::PH_HUNT: begin
        if (b == st_marker) st_phase = fpr_pkg::PH_LEN;
      end
      fpr_pkg::PH_LEN: begin
        st_len = b;
        st_left = b;
        st_sum1 = 8'd0;
        st_sum2 = 8'd0;
        r.frame_length = b;
        if (b == 8'd0) begin
          st_left = fpr_pkg::CsumLowCount;
          st_phase = fpr_pkg::PH_CSUM;
        end else begin
          st_phase = fpr_pkg::PH_PAY;
        end
      end
      fpr_pkg::PH_PAY: begin
        r.event_res = fpr_pkg::EV_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = st_len - st_left;
        r.frame_length = st_len;
        st_sum1 = ones_add8(st_sum1, b);
        st_sum2 = ones_add8(st_sum2, st_sum1);
        if (st_left > 8'd1) begin
          st_left = st_left - 8'd1;
        end else begin
          r.last_payload = 1'b1;
          st_left = fpr_pkg::CsumLowCount;
          st_phase = fpr_pkg::PH_CSUM;
        end
      end
      default: begin
        r.frame_length = st_len;
        if (st_left == fpr_pkg::CsumLowCount) begin
          st_csum_lo = b;
          st_left = fpr_pkg::CsumHighCount;
        end else begin
          r.received_checksum = {b, st_csum_lo};
          r.computed_checksum = {st_sum2, st_sum1};
          r.event_res = (r.received_checksum == r.computed_checksum) ? fpr_pkg::EV_ACCEPT
                                                                     : fpr_pkg::EV_REJECT;
          st_left = 8'd0;
          st_phase = fpr_pkg::PH_HUNT;
        end
      end
    endcase
    return r;
  endfunction

  // Driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  bit took;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rx_byte <= 8'd0;
    end else begin
      took = 1'b0;
      if (in_valid && !in_stall_o) begin
        pending_results.push_back(decode_byte(rx_byte));
        void'(tx_bytes.pop_front());
        acc_cnt++;
        took = 1'b1;
      end
      if (!in_valid || took) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!send_hold && tx_bytes.size() > 0) begin
          in_valid <= 1'b1;
          rx_byte <= tx_bytes[0];
          burst_left--;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off on request
  int stall_mode = 0;
  int mode_left = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt = LongHold;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Monitor: compare each result beat against the oldest prediction
  fpr_pkg::frame_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(event_res_o));
        check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte_o));
        check_field("payload_index", 16'(want.payload_index), 16'(payload_index_o));
        check_field("last_payload", 16'(want.last_payload), 16'(last_payload_o));
        check_field("frame_length", 16'(want.frame_length), 16'(frame_length_o));
        check_field("computed_checksum", want.computed_checksum, computed_checksum_o);
        check_field("received_checksum", want.received_checksum, received_checksum_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("framed_packet_receiver_tb: done, errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    gen_cnt++;
  endtask

  function automatic logic [7:0] pick_payload(input int fill);
    if (fill == 1) return 8'hFF;
    if (fill == 2) return 8'h00;
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return st_marker;
      default: return 8'($urandom);
    endcase
  endfunction

  // fault: 0 good checksum, 1 corrupted checksum, 2 cut short before the checksum
  task automatic send_frame(input int len, input int fault, input int fill);
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [7:0]  b;
    logic [15:0] csum;
    int          stop;
    s1 = 8'd0;
    s2 = 8'd0;
    stop = (fault == 2) ? $urandom_range(0, len) : len;
    push_byte(st_marker);
    push_byte(8'(len));
    for (int i = 0; i < stop; i++) begin
      b = pick_payload(fill);
      s1 = ones_add8(s1, b);
      s2 = ones_add8(s2, s1);
      push_byte(b);
    end
    if (fault == 2) return;
    csum = {s2, s1};
    if (fault == 1) csum = csum ^ (16'd1 << $urandom_range(0, 15));
    push_byte(csum[7:0]);
    push_byte(csum[15:8]);
  endtask

  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom);
    // mostly keep noise off the marker, so frames stay aligned
    if (b == st_marker && $urandom_range(0, 3) != 0) b = b ^ 8'h01;
    push_byte(b);
  endtask

  task automatic send_traffic(input int count);
    int target;
    int r;
    int len;
    int fault;
    target = gen_cnt + count;
    while (gen_cnt < target) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 90) len = $urandom_range(1, 10);
      else len = $urandom_range(11, 40);
      r = $urandom_range(0, 9);
      fault = (r < 7) ? 0 : (r < 9) ? 1 : 2;
      send_frame(len, fault, 0);
    end
  endtask

  // Wait until every beat is taken, every result is back, and the pipe is quiet
  task automatic settle();
    while (acc_cnt != gen_cnt || pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    st_marker = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: noise at the extremes, empty frames, carry fold, bad checksums
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(0, 0, 0);
    send_frame(0, 1, 0);
    send_frame(2, 0, 1);
    send_frame(1, 0, 2);
    send_frame(3, 1, 0);
    settle();

    write_marker(8'h00);
    send_traffic(200);
    // let part of the traffic go out, then hold new beats until every result has drained
    while (gen_cnt - acc_cnt > 100) @(posedge clk_i);
    send_hold = 1'b1;
    @(posedge clk_i);
    while (pending_results.size() != 0 || in_valid) @(posedge clk_i);
    send_hold = 1'b0;
    send_traffic(200);
    settle();

    write_marker(8'hFF);
    send_frame(255, 0, 0);
    send_frame(254, 1, 0);
    send_traffic(150);
    // long receiver hold-off while the sender keeps offering
    hold_req++;
    send_traffic(250);
    settle();

    write_marker(8'($urandom));
    send_traffic(200);
    settle();

    write_marker(fpr_pkg::StartMarkerReset);
    send_traffic(200);
    settle();
    repeat (8) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("framed_packet_receiver_tb: done, clean");
    end else begin
      $display("framed_packet_receiver_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_frame_core.sv
hw/rtl/framed_packet_receiver.sv
dv/framed_packet_receiver_tb.sv
